// File: rtl/text_console_writer_core_assert.svh
// Assertion macros used by the text console writer checker.
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TCW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tcw_pkg.sv
// Shared types, codes and field positions of the text console writer.
package tcw_pkg;

  localparam int DEFAULT_COLUMNS = 80;
  localparam int DEFAULT_ROWS    = 25;

  localparam int CELL_WIDTH = 16;

  localparam logic [7:0] LF_CODE = 8'h0A;
  localparam logic [7:0] CR_CODE = 8'h0D;

  localparam logic [7:0] TEXT_COLOR_RESET     = 8'd15;
  localparam logic [7:0] BACKSPACE_CODE_RESET = 8'd8;
  localparam logic [7:0] HOME_CODE_RESET      = 8'd1;
  localparam logic [7:0] END_CODE_RESET       = 8'd5;

  typedef enum logic [1:0] {
    OP_PUT_CHAR = 2'd0,
    OP_READ_CELL = 2'd1,
    OP_SET_ROW = 2'd2,
    OP_SET_COL = 2'd3
  } tcw_op_t;

  typedef enum logic [1:0] {
    REG_TEXT_COLOR = 2'd0,
    REG_BACKSPACE_CODE = 2'd1,
    REG_HOME_CODE = 2'd2,
    REG_END_CODE = 2'd3
  } tcw_reg_t;

  // Input tdata layout
  localparam int IN_TDATA_W = 32;
  localparam int IN_CHAR_LSB = 0;
  localparam int IN_INDEX_LSB = 8;
  localparam int IN_POS_LSB = 19;

  // Output tdata layout
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_ROW_LSB = 0;
  localparam int OUT_COL_LSB = 5;
  localparam int OUT_LINEAR_LSB = 12;
  localparam int OUT_CHAR_LSB = 23;
  localparam int OUT_COLOR_LSB = 31;
  localparam int OUT_SCROLLED_BIT = 39;

endpackage

// File: rtl/text_console_writer_core.sv
// Text console writer: screen store, cursor control, scroll and clear sequencer.
// Set row, set column and put char without scroll register their item at acceptance,
// one item per cycle while the result is taken; read cell adds one RAM read before it.
// A scroll copies one cell per cycle through the single RAM write port, then the bottom
// row is zeroed. After rst a clearing pass writes every cell to zero; no item is accepted
// until it ends, config writes always are.
module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // char_code [7:0], cell_index [18:8], position [25:19], zero pad [31:26]
  input  logic [tcw_pkg::IN_TDATA_W-1:0]   s_tdata,
  // operation [1:0]
  input  logic [1:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // cur_row [4:0], cur_column [11:5], cursor_linear [22:12], cell_char [30:23],
  // cell_color [38:31], scrolled [39]
  output logic [tcw_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [7:0]                       cfg_data
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW = $clog2(CELLS);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS + 1);

  typedef enum logic [1:0] {ST_WIPE, ST_IDLE, ST_READ, ST_MOVE} state_t;

  state_t state;
  logic [AW-1:0] cnt;
  logic pend_valid;
  logic [AW-1:0] pend_addr;
  logic wipe_scroll;
  logic rd_ok;

  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [CW-1:0] line_end;

  logic [7:0] text_color;
  logic [7:0] backspace_code;
  logic [7:0] home_code;
  logic [7:0] end_code;

  logic [4:0] out_row;
  logic [6:0] out_col;
  logic [10:0] out_linear;
  logic [7:0] out_char;
  logic [7:0] out_color;
  logic out_scrolled;
  logic out_load;

  logic [7:0] in_char;
  logic [10:0] in_index;
  logic [6:0] in_pos;
  tcw_op_t in_op;
  logic accept;

  // put char datapath
  logic [RW-1:0] r0, r1;
  logic [CW-1:0] c0, c1, le1;
  logic put_scroll;
  logic put_we;
  logic [CW-1:0] put_wcol;
  logic [AW-1:0] put_addr;
  logic [CELL_WIDTH-1:0] put_data;

  logic [RW-1:0] row_next;
  logic [CW-1:0] col_next;

  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [CELL_WIDTH-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [CELL_WIDTH-1:0] ram_rdata;

  assign in_char = s_tdata[IN_CHAR_LSB +: 8];
  assign in_index = s_tdata[IN_INDEX_LSB +: 11];
  assign in_pos = s_tdata[IN_POS_LSB +: 7];
  assign in_op = tcw_op_t'(s_tuser);

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign m_tdata = {out_scrolled, out_color, out_char, out_linear, out_col, out_row};

  // raise the result: direct ops at acceptance, a read in the read state, a scroll at its end
  assign out_load = (state == ST_READ) ||
                    (state == ST_IDLE && accept && in_op != OP_READ_CELL &&
                     !(in_op == OP_PUT_CHAR && put_scroll)) ||
                    (state == ST_WIPE && !pend_valid && cnt == AW'(CELLS - 1) &&
                     wipe_scroll);

  always_comb begin
    // resolve a pending wrap first
    if (int'(col) >= COLUMNS) begin
      c0 = '0;
      r0 = (int'(row) >= ROWS - 1) ? RW'(ROWS - 1) : row + 1'b1;
    end else begin
      c0 = col;
      r0 = row;
    end
    r1 = r0;
    c1 = c0;
    le1 = line_end;
    put_we = 1'b0;
    put_wcol = c0;
    put_data = {text_color, in_char};
    if (in_char == LF_CODE || in_char == CR_CODE) begin
      r1 = (int'(r0) >= ROWS - 1) ? RW'(ROWS - 1) : r0 + 1'b1;
      c1 = '0;
      le1 = '0;
    end else if (in_char == backspace_code) begin
      c1 = (c0 != '0) ? c0 - 1'b1 : c0;
      put_we = 1'b1;
      put_wcol = c1;
      put_data = '0;
    end else if (in_char == home_code) begin
      c1 = '0;
    end else if (in_char == end_code) begin
      c1 = line_end;
    end else begin
      put_we = 1'b1;
      c1 = c0 + 1'b1;
      le1 = (int'(line_end) < COLUMNS) ? line_end + 1'b1 : line_end;
    end
    put_scroll = int'(r1) >= ROWS - 1;
    put_addr = AW'(int'(r0) * COLUMNS + int'(put_wcol));
  end

  always_comb begin
    row_next = row;
    col_next = col;
    case (in_op)
      OP_PUT_CHAR: begin
        row_next = put_scroll ? RW'(ROWS - 2) : r1;
        col_next = put_scroll ? '0 : c1;
      end
      OP_SET_ROW: row_next = (int'(in_pos) > ROWS - 1) ? RW'(ROWS - 1) : RW'(in_pos);
      OP_SET_COL: col_next = (int'(in_pos) > COLUMNS - 1) ? CW'(COLUMNS - 1) : CW'(in_pos);
      default: ;
    endcase
  end

  // write port: put char, then copy writes, then zero fill
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = put_addr;
    ram_wdata = put_data;
    if (state == ST_IDLE) begin
      ram_we = accept && (in_op == OP_PUT_CHAR) && put_we;
    end else if (pend_valid) begin
      ram_we = 1'b1;
      ram_waddr = pend_addr;
      ram_wdata = ram_rdata;
    end else if (state == ST_WIPE) begin
      ram_we = 1'b1;
      ram_waddr = cnt;
      ram_wdata = '0;
    end
    ram_raddr = (state == ST_MOVE) ? AW'(int'(cnt) + COLUMNS) : AW'(in_index);
  end

  tcw_ram #(
    .WIDTH(CELL_WIDTH),
    .DEPTH(CELLS)
  ) u_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= TEXT_COLOR_RESET;
      backspace_code <= BACKSPACE_CODE_RESET;
      home_code <= HOME_CODE_RESET;
      end_code <= END_CODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (tcw_reg_t'(cfg_index))
        REG_TEXT_COLOR: text_color <= cfg_data;
        REG_BACKSPACE_CODE: backspace_code <= cfg_data;
        REG_HOME_CODE: home_code <= cfg_data;
        REG_END_CODE: end_code <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WIPE;
      cnt <= '0;
      pend_valid <= 1'b0;
      wipe_scroll <= 1'b0;
      m_tvalid <= 1'b0;
      row <= '0;
      col <= '0;
      line_end <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            row <= row_next;
            col <= col_next;
            out_row <= 5'(row_next);
            out_col <= 7'(col_next);
            out_linear <= 11'(int'(row_next) * COLUMNS + int'(col_next));
            out_char <= '0;
            out_color <= '0;
            out_scrolled <= (in_op == OP_PUT_CHAR) && put_scroll;
            rd_ok <= int'(in_index) < CELLS;
            if (in_op == OP_READ_CELL) begin
              state <= ST_READ;
            end else if (in_op == OP_PUT_CHAR && put_scroll) begin
              line_end <= '0;
              cnt <= '0;
              state <= ST_MOVE;
            end else begin
              if (in_op == OP_PUT_CHAR) begin
                line_end <= le1;
              end
            end
          end
        end
        ST_READ: begin
          out_char <= rd_ok ? ram_rdata[7:0] : '0;
          out_color <= rd_ok ? ram_rdata[15:8] : '0;
          state <= ST_IDLE;
        end
        ST_MOVE: begin
          // read row below, write it back one row up next cycle
          pend_valid <= 1'b1;
          pend_addr <= cnt;
          if (cnt == AW'(CELLS - COLUMNS - 1)) begin
            cnt <= AW'(CELLS - COLUMNS);
            wipe_scroll <= 1'b1;
            state <= ST_WIPE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_WIPE: begin
          if (pend_valid) begin
            pend_valid <= 1'b0;
          end else if (cnt == AW'(CELLS - 1)) begin
            state <= ST_IDLE;
            wipe_scroll <= 1'b0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tcw_checker.sv
// Port-level checks of the text console writer, bound to the top level.
module tcw_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [tcw_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import tcw_pkg::*;
`include "text_console_writer_core_assert.svh"

  `TCW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "item dropped or changed while stalled")
  `TCW_ASSERT_IMP(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready, "input taken while result stalled")
  `TCW_ASSERT_IMP(a_scroll_no_cell, m_tvalid && m_tdata[OUT_SCROLLED_BIT], m_tdata[OUT_SCROLLED_BIT-1:OUT_CHAR_LSB] == '0, "scroll item carries cell data")
  `TCW_ASSERT_IMP(a_scroll_col_zero, m_tvalid && m_tdata[OUT_SCROLLED_BIT], m_tdata[OUT_LINEAR_LSB-1:OUT_COL_LSB] == '0, "scroll item with nonzero column")

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);

// File: test/tb_text_console_writer_core.sv
// Self-checking testbench for the text console writer core.
`timescale 1ns / 1ps

module tb_text_console_writer_core;
  import tcw_pkg::*;

  localparam int N_COLS  = DEFAULT_COLUMNS;
  localparam int N_ROWS  = DEFAULT_ROWS;
  localparam int N_CELLS = N_COLS * N_ROWS;
  localparam int PHASE_ITEMS = 300;

  // Field order matches m_tdata, cursor_row in the lowest bits
  typedef struct packed {
    logic       scrolled;
    logic [7:0] color;
    logic [7:0] chr;
    logic [10:0] linear;
    logic [6:0] col;
    logic [4:0] row;
  } console_result_t;

  typedef struct packed {
    tcw_op_t         op;
    logic [7:0]      code;
    logic [10:0]     idx;
    logic [6:0]      pos;
    logic            fixed;
    console_result_t res;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = OP_PUT_CHAR;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_TEXT_COLOR;
  logic [7:0] cfg_data = '0;

  // Console shadow state
  logic [15:0] cells_model [N_CELLS];
  int row_now, col_now, line_len;
  logic [7:0] pen_color, erase_code, home_key, end_key;

  console_result_t pending_q[$];
  directed_row_t   directed_q[$];
  int unsigned err_count = 0;
  int unsigned send_idle = 0;
  int unsigned sink_stall = 0;

  text_console_writer_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    #(100_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int cell_of(int r, int c);
    int i;
    i = r * N_COLS + c;
    return (i < N_CELLS) ? i : N_CELLS - 1;
  endfunction

  function automatic void bump_row();
    row_now = (row_now < N_ROWS - 1) ? row_now + 1 : N_ROWS - 1;
  endfunction

  function automatic console_result_t console_step(tcw_op_t op, logic [7:0] code,
                                                   logic [10:0] idx, logic [6:0] pos);
    console_result_t r;
    int lin;
    r = '0;
    case (op)
      OP_PUT_CHAR: begin
        if (col_now >= N_COLS) begin
          col_now = 0;
          bump_row();
        end
        if (code == LF_CODE || code == CR_CODE) begin
          bump_row();
          col_now = 0;
          line_len = 0;
        end else if (code == erase_code) begin
          if (col_now > 0) col_now--;
          cells_model[cell_of(row_now, col_now)] = '0;
        end else if (code == home_key) begin
          col_now = 0;
        end else if (code == end_key) begin
          col_now = line_len;
        end else begin
          cells_model[cell_of(row_now, col_now)] = {pen_color, code};
          col_now++;
          if (line_len < N_COLS) line_len++;
        end
        // Hitting the last row shifts the screen up and blanks the bottom row
        if (row_now >= N_ROWS - 1) begin
          for (int i = 0; i < N_CELLS; i++)
            cells_model[i] = (i < N_CELLS - N_COLS) ? cells_model[i + N_COLS] : '0;
          row_now = N_ROWS - 2;
          col_now = 0;
          line_len = 0;
          r.scrolled = 1'b1;
        end
      end
      OP_READ_CELL: begin
        if (idx < N_CELLS) begin
          r.chr   = cells_model[idx][7:0];
          r.color = cells_model[idx][15:8];
        end
      end
      OP_SET_ROW: row_now = (pos > N_ROWS - 1) ? N_ROWS - 1 : pos;
      default:    col_now = (pos > N_COLS - 1) ? N_COLS - 1 : pos;
    endcase
    lin = row_now * N_COLS + col_now;
    r.row = row_now[4:0];
    r.col = col_now[6:0];
    r.linear = lin[10:0];
    return r;
  endfunction

  // Random stall on the result side
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall);
  end

  always @(posedge clk) begin
    console_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = console_result_t'(m_tdata);
      if (pending_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected item: %h", m_tdata);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= 10)
            $display({"mismatch row %0d/%0d col %0d/%0d lin %0d/%0d char %h/%h ",
                      "color %h/%h scrolled %0d/%0d (exp/got)"},
                     want.row, got.row, want.col, got.col, want.linear, got.linear,
                     want.chr, got.chr, want.color, got.color, want.scrolled, got.scrolled);
        end
      end
    end
  end

  task automatic send_item(tcw_op_t op, logic [7:0] code, logic [10:0] idx,
                           logic [6:0] pos, logic fixed, console_result_t res);
    console_result_t pred;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, pos, idx, code};
    do @(posedge clk); while (!s_tready);
    pred = console_step(op, code, idx, pos);
    pending_q.push_back(fixed ? res : pred);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic program_console(logic [7:0] color, logic [7:0] erase,
                                 logic [7:0] home, logic [7:0] fin);
    tcw_reg_t regs [4];
    logic [7:0] vals [4];
    regs = '{REG_TEXT_COLOR, REG_BACKSPACE_CODE, REG_HOME_CODE, REG_END_CODE};
    vals = '{color, erase, home, fin};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    pen_color  = color;
    erase_code = erase;
    home_key   = home;
    end_key    = fin;
  endtask

  task automatic plan(tcw_op_t op, logic [7:0] code, logic [10:0] idx, logic [6:0] pos,
                      int fixed, int r, int c, int lin, logic [7:0] chr,
                      logic [7:0] color, int scr);
    directed_row_t d;
    d.op = op; d.code = code; d.idx = idx; d.pos = pos; d.fixed = fixed[0];
    d.res.row = r[4:0]; d.res.col = c[6:0]; d.res.linear = lin[10:0];
    d.res.chr = chr; d.res.color = color; d.res.scrolled = scr[0];
    directed_q.push_back(d);
  endtask

  task automatic send_random();
    tcw_op_t op;
    logic [7:0] code;
    logic [10:0] idx;
    logic [6:0] pos;
    int unsigned pick, sub;
    pick = $urandom_range(99);
    sub  = $urandom_range(99);
    code = 8'($urandom_range(255));
    idx  = 11'($urandom_range(2047));
    pos  = 7'($urandom_range(127));
    if (pick < 68) begin
      op = OP_PUT_CHAR;
      if (sub < 5)       code = sub[0] ? LF_CODE : CR_CODE;
      else if (sub < 10) code = erase_code;
      else if (sub < 14) code = home_key;
      else if (sub < 18) code = end_key;
    end else if (pick < 82) begin
      op = OP_READ_CELL;
      // look mostly around the cursor where text lands
      if (sub < 60) idx = 11'(row_now * N_COLS + $urandom_range(N_COLS - 1));
    end else if (pick < 90) begin
      op = OP_SET_ROW;
      if (sub < 50) pos = 7'($urandom_range(N_ROWS - 3));
    end else begin
      op = OP_SET_COL;
    end
    send_item(op, code, idx, pos, 1'b0, '0);
  endtask

  initial begin
    directed_row_t d;
    for (int i = 0; i < N_CELLS; i++) cells_model[i] = '0;
    row_now = 0;
    col_now = 0;
    line_len = 0;
    pen_color  = TEXT_COLOR_RESET;
    erase_code = BACKSPACE_CODE_RESET;
    home_key   = HOME_CODE_RESET;
    end_key    = END_CODE_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part under reset settings
    plan(OP_READ_CELL, 8'h00, 11'd0,    7'd0,   1,  0,  0,    0, 8'h00, 8'h00, 0);
    plan(OP_READ_CELL, 8'hFF, 11'd1999, 7'd0,   1,  0,  0,    0, 8'h00, 8'h00, 0);
    plan(OP_READ_CELL, 8'h00, 11'd2047, 7'd127, 1,  0,  0,    0, 8'h00, 8'h00, 0);
    plan(OP_SET_ROW,   8'h00, 11'd0,    7'd127, 1, 24,  0, 1920, 8'h00, 8'h00, 0);
    plan(OP_SET_COL,   8'h00, 11'd0,    7'd127, 1, 24, 79, 1999, 8'h00, 8'h00, 0);
    plan(OP_PUT_CHAR,  8'h41, 11'd0,    7'd0,   1, 23,  0, 1840, 8'h00, 8'h00, 1);
    plan(OP_READ_CELL, 8'h00, 11'd1919, 7'd0,   1, 23,  0, 1840, 8'h41, 8'h0F, 0);
    plan(OP_SET_ROW,   8'h00, 11'd0,    7'd0,   1,  0,  0,    0, 8'h00, 8'h00, 0);
    plan(OP_PUT_CHAR,  8'hFF, 11'd0,    7'd0,   1,  0,  1,    1, 8'h00, 8'h00, 0);
    plan(OP_PUT_CHAR,  8'h00, 11'd0,    7'd0,   1,  0,  2,    2, 8'h00, 8'h00, 0);
    plan(OP_PUT_CHAR,  8'h08, 11'd0,    7'd0,   1,  0,  1,    1, 8'h00, 8'h00, 0);
    plan(OP_READ_CELL, 8'h00, 11'd1,    7'd0,   1,  0,  1,    1, 8'h00, 8'h00, 0);
    plan(OP_PUT_CHAR,  8'h05, 11'd0,    7'd0,   1,  0,  2,    2, 8'h00, 8'h00, 0);
    plan(OP_PUT_CHAR,  8'h01, 11'd0,    7'd0,   1,  0,  0,    0, 8'h00, 8'h00, 0);
    plan(OP_PUT_CHAR,  8'h08, 11'd0,    7'd0,   1,  0,  0,    0, 8'h00, 8'h00, 0);
    plan(OP_READ_CELL, 8'h00, 11'd0,    7'd0,   1,  0,  0,    0, 8'h00, 8'h00, 0);
    plan(OP_PUT_CHAR,  LF_CODE, 11'd0,  7'd0,   1,  1,  0,   80, 8'h00, 8'h00, 0);
    plan(OP_PUT_CHAR,  CR_CODE, 11'd0,  7'd0,   1,  2,  0,  160, 8'h00, 8'h00, 0);
    plan(OP_SET_COL,   8'h00, 11'd0,    7'd79,  1,  2, 79,  239, 8'h00, 8'h00, 0);
    plan(OP_PUT_CHAR,  8'h42, 11'd0,    7'd0,   1,  2, 80,  240, 8'h00, 8'h00, 0);
    plan(OP_PUT_CHAR,  8'h43, 11'd0,    7'd0,   1,  3,  1,  241, 8'h00, 8'h00, 0);
    plan(OP_READ_CELL, 8'h00, 11'd240,  7'd0,   1,  3,  1,  241, 8'h43, 8'h0F, 0);
    plan(OP_SET_COL,   8'h00, 11'd0,    7'd79,  0,  0,  0,    0, 8'h00, 8'h00, 0);
    plan(OP_PUT_CHAR,  8'h44, 11'd0,    7'd0,   0,  0,  0,    0, 8'h00, 8'h00, 0);
    plan(OP_PUT_CHAR,  8'h05, 11'd0,    7'd0,   0,  0,  0,    0, 8'h00, 8'h00, 0);
    plan(OP_SET_ROW,   8'h00, 11'd0,    7'd23,  0,  0,  0,    0, 8'h00, 8'h00, 0);
    plan(OP_PUT_CHAR,  LF_CODE, 11'd0,  7'd0,   1, 23,  0, 1840, 8'h00, 8'h00, 1);
    while (directed_q.size() != 0) begin
      d = directed_q.pop_front();
      send_item(d.op, d.code, d.idx, d.pos, d.fixed, d.res);
    end
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  sink_stall = 0;  end
        1: begin send_idle = 57; sink_stall = 0;  end
        2: begin send_idle = 0;  sink_stall = 57; end
        default: begin send_idle = 8; sink_stall = 8; end
      endcase
      case (ph)
        0: program_console(8'h00, 8'hFF, 8'h00, 8'h09);
        1: program_console(8'hFF, 8'h7F, 8'h1B, 8'hFF);
        // backspace hidden behind line feed; home and end share a code
        2: program_console(8'($urandom_range(255)), LF_CODE, 8'h02, 8'h02);
        3: program_console(8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(255)), 8'($urandom_range(255)));
        4: program_console(TEXT_COLOR_RESET, BACKSPACE_CODE_RESET, HOME_CODE_RESET,
                           END_CODE_RESET);
        default: program_console(8'($urandom_range(255)), 8'($urandom_range(31)),
                                 8'($urandom_range(31)), 8'($urandom_range(31)));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == PHASE_ITEMS / 2) wait_drained();
        send_random();
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
